// ===== sv/sha_pkg.sv =====
`timescale 1ns / 1ps

package sha_pkg;

   localparam int unsigned NUM_ROUNDS = 64;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS = 8;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;
   localparam logic [5:0] LAST_ROUND_IDX = 6'd63;
   localparam logic [5:0] LAST_BYTE_SLOT = 6'd63;
   localparam logic [5:0] LEN_SLOT_START = 6'd56;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic KIND_DATA = 1'b0;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
      logic        oversize;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_PAD1,
      PH_PAD2
   } phase_type;

   typedef struct packed {
      logic       write_byte;
      logic       pad;
      logic       len;
      logic       clear_low;
      logic       load;
      logic       round;
      logic [5:0] round_idx;
      logic       fold;
      logic       restart;
      logic [2:0] out_idx;
   } cmd_type;

   typedef struct packed {
      logic slot_last;
      logic tail_two;
   } status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      case (idx)
         3'd0: init_hash = 32'h6a09e667;
         3'd1: init_hash = 32'hbb67ae85;
         3'd2: init_hash = 32'h3c6ef372;
         3'd3: init_hash = 32'ha54ff53a;
         3'd4: init_hash = 32'h510e527f;
         3'd5: init_hash = 32'h9b05688c;
         3'd6: init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;
         6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;
         6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;
         6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;
         6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;
         6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;
         6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;
         6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;
         6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;
         6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;
         6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;
         6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;
         6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;
         6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;
         6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;
         6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;
         6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;
         6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;
         6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;
         6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;
         6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;
         6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;
         6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;
         6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;
         6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;
         6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;
         6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;
         6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;
         6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;
         6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;
         6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;
         6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;
         default: round_k = 32'hc67178f2;
      endcase
   endfunction

endpackage

// ===== sv/sha_dp.sv =====
`timescale 1ns / 1ps

module sha_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          data_byte,
   input  sha_pkg::cmd_type    cmd,
   output sha_pkg::status_type status,
   output sha_pkg::rsp_type    rsp_word
);
   import sha_pkg::*;

   logic [31:0] block_ff [BLOCK_WORDS];
   logic [31:0] block_in [BLOCK_WORDS];
   logic [31:0] work_ff  [HASH_WORDS];
   logic [31:0] work_in  [HASH_WORDS];
   logic [31:0] chain_ff [HASH_WORDS];
   logic [31:0] chain_in [HASH_WORDS];
   logic [63:0] count_ff;
   logic [63:0] count_in;
   logic        ovf_ff;
   logic        ovf_in;

   logic [5:0]  slot;
   logic [3:0]  slot_word;
   logic [1:0]  slot_lane;
   logic [31:0] ins_bits;
   logic [63:0] count_inc;
   logic [63:0] bit_len;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] w_new;

   assign slot      = count_ff[5:0];
   assign slot_word = slot[5:2];
   assign slot_lane = slot[1:0];
   // big-endian lane: byte 0 of a word goes to bits 31:24
   assign ins_bits  = {24'd0, (cmd.pad ? PAD_BYTE : data_byte)} << {~slot_lane, 3'b000};
   assign count_inc = count_ff + 64'd1;
   assign bit_len   = {count_ff[60:0], 3'b000};

   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + round_k(cmd.round_idx) + block_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign w_new = small_sigma1(block_ff[14]) + block_ff[9]
                + small_sigma0(block_ff[1]) + block_ff[0];

   always_comb begin
      block_in = block_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;

      if (cmd.write_byte || cmd.pad) begin
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            if (4'(i) == slot_word) begin
               block_in[i] = (slot_lane == 2'd0) ? ins_bits : (block_ff[i] | ins_bits);
            end else if (cmd.pad && (4'(i) > slot_word)) begin
               block_in[i] = 32'd0;
            end
         end
      end

      if (cmd.write_byte) begin
         count_in = count_inc;
         if (count_inc[63:61] != 3'd0) begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.len) begin
         if (cmd.clear_low) begin
            for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
               block_in[i] = 32'd0;
            end
         end
         block_in[BLOCK_WORDS-2] = bit_len[63:32];
         block_in[BLOCK_WORDS-1] = bit_len[31:0];
      end

      if (cmd.load) begin
         work_in = chain_ff;
      end

      if (cmd.round) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
         // schedule window slides one word per round
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            block_in[i] = block_ff[i+1];
         end
         block_in[BLOCK_WORDS-1] = w_new;
      end

      if (cmd.fold) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end

      if (cmd.restart) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_in[i] = init_hash(3'(i));
         end
         count_in = 64'd0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff  <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_ff[i] <= init_hash(3'(i));
         end
         count_ff <= 64'd0;
         ovf_ff   <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign status.slot_last = (slot == LAST_BYTE_SLOT);
   assign status.tail_two  = (slot >= LEN_SLOT_START);

   assign rsp_word.digest_word = chain_ff[cmd.out_idx];
   assign rsp_word.word_index  = cmd.out_idx;
   assign rsp_word.last_word   = (cmd.out_idx == LAST_WORD_IDX);
   assign rsp_word.oversize    = ovf_ff;

endmodule

// ===== sv/sha_ctrl.sv =====
`timescale 1ns / 1ps

module sha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sha_pkg::status_type status,
   output sha_pkg::cmd_type    cmd
);
   import sha_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   phase_type  phase_ff;
   phase_type  phase_in;
   logic [5:0] round_ff;
   logic [5:0] round_in;
   logic [2:0] out_ff;
   logic [2:0] out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DATA;
         round_ff <= 6'd0;
         out_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         round_ff <= round_in;
         out_ff   <= out_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      round_in      = round_ff;
      out_in        = out_ff;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.out_idx   = out_ff;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == KIND_DATA) begin
                  cmd.write_byte = 1'b1;
                  if (status.slot_last) begin
                     phase_in = PH_DATA;
                     state_in = ST_LOAD;
                  end
               end else begin
                  cmd.pad = 1'b1;
                  if (status.tail_two) begin
                     phase_in = PH_PAD1;
                     state_in = ST_LOAD;
                  end else begin
                     phase_in = PH_PAD2;
                     state_in = ST_LEN;
                  end
               end
            end
         end
         ST_LEN: begin
            cmd.len       = 1'b1;
            cmd.clear_low = (phase_ff == PH_PAD1);
            phase_in      = PH_PAD2;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            round_in = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == LAST_ROUND_IDX) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            case (phase_ff)
               PH_DATA: state_in = ST_IDLE;
               PH_PAD1: state_in = ST_LEN;
               PH_PAD2: begin
                  out_in   = 3'd0;
                  state_in = ST_OUT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               out_in = out_ff + 3'd1;
               if (out_ff == LAST_WORD_IDX) begin
                  cmd.restart = 1'b1;
                  phase_in    = PH_DATA;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("input accepted outside idle");

   a_rounds_to_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == LAST_ROUND_IDX) |=> (state_ff == ST_FOLD))
      else $error("last round not followed by fold");

   a_load_starts_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (state_ff == ST_ROUND && round_ff == 6'd0))
      else $error("load not followed by round zero");

   a_last_word_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && out_ff == LAST_WORD_IDX) |=> (state_ff == ST_IDLE))
      else $error("no return to idle after last digest word");
`endif

endmodule

// ===== sv/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// Flow: bytes are accepted only while idle; the byte that fills a 64-byte block then
//   runs load, 64 rounds and fold with the input stalled. End of message: length, load,
//   rounds, fold for one padding block, or two such passes; then 8 words, one per cycle
//   when rsp_stall is low. One block at a time uses the single shared round unit.
// Reset: synchronous, active high; chaining state to the SHA-256 initial values,
//   byte count and length error cleared, controller idle.
module sha256_byte_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_word
);
   import sha_pkg::*;

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;

   // Controller: sequences byte writes, padding, the 64 rounds of each block,
   // the chaining fold and the eight-word digest readout.
   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_word.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: block buffer doubling as the message schedule window,
   // working variables a..h, chaining hash, byte counter and overflow flag.
   sha_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_word.data_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== bench/sha256_byte_stream_hasher_tb.sv =====
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;
   import sha_pkg::*;

   // End-of-message marker; data bytes use KIND_DATA from the package.
   localparam logic KIND_END = 1'b1;

   // Stimulus sizing and pressure knobs.
   localparam int RANDOM_ITEMS   = 420;
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int HOLD_AFTER     = 48;    // words checked before the hold-off starts
   localparam int PAUSE_AFTER    = 6;     // random message after which the sender drains
   localparam int SETTLE_CYCLES  = 200;   // quiet time at the end

   // Digest scoreboard: runs its own SHA-256 over the accepted bytes and
   // queues the eight digest words each end of message should produce.
   class hash_scoreboard;
      rsp_type     digest_queue[$];
      logic [31:0] chain[8];
      logic [31:0] block[16];
      logic [63:0] byte_count;
      logic        overflow;
      logic [31:0] k_table[64];
      int          mismatches;
      int          checked;

      function new();
         k_table = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         block      = '{default: 32'h0};
         mismatches = 0;
         checked    = 0;
         restart();
      endfunction

      function void restart();
         chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
         byte_count = 64'd0;
         overflow   = 1'b0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // Big-endian byte lane; lane 0 starts a fresh word.
      function void put_byte(logic [5:0] pos, logic [7:0] value);
         logic [31:0] lane_val;
         lane_val = {24'h0, value} << ((3 - pos[1:0]) * 8);
         if (pos[1:0] == 2'd0) begin
            block[pos[5:2]] = lane_val;
         end else begin
            block[pos[5:2]] = block[pos[5:2]] | lane_val;
         end
      endfunction

      function void compress();
         logic [31:0] w[64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) w[i] = block[i];
         for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + k_table[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      // Called once per accepted input word.
      function void note_item(req_type item);
         logic [5:0]  slot;
         logic [63:0] bit_len;
         rsp_type     word;
         slot = byte_count[5:0];
         if (item.kind == KIND_DATA) begin
            put_byte(slot, item.data_byte);
            byte_count++;
            if (byte_count[63:61] != 3'd0) overflow = 1'b1;
            if (byte_count[5:0] == 6'd0) compress();
         end else begin
            bit_len = byte_count << 3;
            put_byte(slot, PAD_BYTE);
            for (int i = slot[5:2] + 1; i < 16; i++) block[i] = 32'h0;
            // no room for the length: spill into a second padding block
            if (slot >= LEN_SLOT_START) begin
               compress();
               for (int i = 0; i < 14; i++) block[i] = 32'h0;
            end
            block[14] = bit_len[63:32];
            block[15] = bit_len[31:0];
            compress();
            for (int i = 0; i < 8; i++) begin
               word.digest_word = chain[i];
               word.word_index  = 3'(i);
               word.last_word   = (i == 7);
               word.oversize    = overflow;
               digest_queue     = {digest_queue, word};
            end
            restart();
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("tb: %s mismatch at word %0d: got %h want %h", what, checked, got, want);
         mismatches++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (digest_queue.size() == 0) begin
            report_mismatch("unexpected word", got.digest_word, 32'h0);
         end else begin
            want = digest_queue.pop_front();
            if (got.digest_word !== want.digest_word)
               report_mismatch("digest_word", got.digest_word, want.digest_word);
            if (got.word_index !== want.word_index)
               report_mismatch("word_index", got.word_index, want.word_index);
            if (got.last_word !== want.last_word)
               report_mismatch("last_word", got.last_word, want.last_word);
            if (got.oversize !== want.oversize)
               report_mismatch("oversize", got.oversize, want.oversize);
         end
         checked++;
      endtask

      function int pending();
         return digest_queue.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   hash_scoreboard sb;

   // Sender pacing state: bytes left in the current burst.
   int burst_left;
   int items_sent;
   // Message lengths around the 55/56 and 64-byte padding boundaries.
   int boundary_lengths[9] = '{0, 1, 54, 57, 65, 119, 120, 127, 128};
   int forced_lengths[4]   = '{55, 56, 63, 64};

   sha256_byte_stream_hasher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // 8 ns clock.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Result monitor: a word moves on a rising edge with valid high, stall low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
   end

   // Bursty sender: between bursts the valid usually drops for a random gap.
   // Runs at a falling edge with valid possibly still high from the last word.
   task automatic pace();
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         // mix short bursts with long stretches of back-to-back words
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // Offer one word and hold it until the block takes it.
   task automatic send_item(input logic kind, input logic [7:0] data);
      req_type item;
      item.kind      = kind;
      item.data_byte = data;
      pace();
      req_valid = 1'b1;
      req_word  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
      // end-of-message carries a random byte that the block must ignore
      send_item(KIND_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Receiver: stall pattern changes per segment. Once, after a few digests,
   // it holds off for a long stretch while the sender keeps offering bytes,
   // so the block backs up and stalls its input.
   initial begin : receiver
      int  mode;
      int  span;
      int  phase;
      bit  held;
      rsp_stall = 1'b0;
      held      = 1'b0;
      phase     = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            phase++;
            if (!held && sb.checked >= HOLD_AFTER && rsp_valid) begin
               rsp_stall = 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
               held = 1'b1;
            end
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               2: rsp_stall = ($urandom_range(0, 3) != 0);
               default: rsp_stall = phase[0];
            endcase
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int msg_count;
      int len;
      req_valid  = 1'b0;
      req_word   = '0;
      reset      = 1'b1;
      burst_left = 0;
      items_sent = 0;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty message, "abc", single 0xff and 0x00 bytes. The
      // end-of-message words carry junk bytes that must not reach the hash.
      send_item(KIND_END, 8'h00);
      send_item(KIND_DATA, 8'h61);
      send_item(KIND_DATA, 8'h62);
      send_item(KIND_DATA, 8'h63);
      send_item(KIND_END, 8'hff);
      send_item(KIND_DATA, 8'hff);
      send_item(KIND_END, 8'h00);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_END, 8'h80);
      wait_drained();

      // Random messages: the first few sit on the padding boundaries (one
      // versus two final blocks, exact block fill), then mostly short ones.
      items_sent = 0;
      msg_count  = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (msg_count < 4) begin
            len = forced_lengths[msg_count];
         end else if ($urandom_range(0, 3) == 0) begin
            len = boundary_lengths[$urandom_range(0, 8)];
         end else begin
            len = $urandom_range(0, 40);
         end
         send_message(len);
         msg_count++;
         // let the block drain completely once mid-run
         if (msg_count == PAUSE_AFTER) wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sha256_byte_stream_hasher.f =====
sv/sha_pkg.sv
sv/sha_dp.sv
sv/sha_ctrl.sv
sv/sha256_byte_stream_hasher.sv
bench/sha256_byte_stream_hasher_tb.sv
